FILE: hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHECK_IMPL(label, clock, rstn, prop) \
    label: assert property (@(posedge clock) disable iff (!rstn) prop) \
        else $error("check failed");
`define CHECK_NEXT(label, clock, rstn, pre, post) \
    label: assert property (@(posedge clock) disable iff (!rstn) (pre) |=> (post)) \
        else $error("check failed");
`else
`define CHECK_IMPL(label, clock, rstn, prop)
`define CHECK_NEXT(label, clock, rstn, pre, post)
`endif
`endif

FILE: hdl/fdtd_pkg.sv
package fdtd_pkg;
    localparam int FIELD_BITS = 18;
    localparam int GRID_BITS  = 6;
    localparam int ADDR_BITS  = 2 * GRID_BITS;
    localparam int DEPTH      = 1 << ADDR_BITS;
    localparam int CURL_BITS  = FIELD_BITS + 2;
    localparam int SUM_BITS   = FIELD_BITS + 3;

    localparam logic [GRID_BITS-1:0] GRID_LAST = {GRID_BITS{1'b1}};

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] FIELD_EZ = 2'd0;
    localparam logic [1:0] FIELD_HX = 2'd1;
    localparam logic [1:0] FIELD_HY = 2'd2;

    localparam logic REG_SOURCE_ROW = 1'b0;
    localparam logic REG_SOURCE_COL = 1'b1;

    typedef logic signed [FIELD_BITS-1:0] field_t;

    typedef struct packed {
        field_t base;
        field_t pa;
        field_t na;
        field_t pb;
        field_t nb;
        logic   negate;
    } alu_op_t;

    typedef struct packed {
        field_t value;
        logic   clip;
    } alu_res_t;
endpackage

FILE: hdl/fdtd_ram.sv
module fdtd_ram #(
    parameter int WIDTH = 18,
    parameter int ABITS = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [ABITS-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [ABITS-1:0] raddr_a,
    input  logic [ABITS-1:0] raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);
    logic [WIDTH-1:0] mem [0:(1<<ABITS)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

FILE: hdl/fdtd_alu.sv
module fdtd_alu
    import fdtd_pkg::*;
(
    input  alu_op_t  op,
    output alu_res_t res
);
    logic signed [CURL_BITS-1:0] curl;
    logic signed [CURL_BITS-1:0] half;
    logic signed [SUM_BITS-1:0]  sum;
    logic signed [SUM_BITS-1:0]  fmax;
    logic signed [SUM_BITS-1:0]  fmin;

    always_comb
    begin
        curl = CURL_BITS'(op.pa) - CURL_BITS'(op.na) + CURL_BITS'(op.pb) - CURL_BITS'(op.nb);
        half = curl >>> 1;
        if (op.negate)
        begin
            sum = SUM_BITS'(op.base) - SUM_BITS'(half);
        end
        else
        begin
            sum = SUM_BITS'(op.base) + SUM_BITS'(half);
        end
        fmax = SUM_BITS'({1'b0, {(FIELD_BITS-1){1'b1}}});
        fmin = -fmax - SUM_BITS'(1);
        if (sum > fmax)
        begin
            res.value = fmax[FIELD_BITS-1:0];
            res.clip  = 1'b1;
        end
        else if (sum < fmin)
        begin
            res.value = fmin[FIELD_BITS-1:0];
            res.clip  = 1'b1;
        end
        else
        begin
            res.value = sum[FIELD_BITS-1:0];
            res.clip  = 1'b0;
        end
    end
endmodule

FILE: hdl/fdtd_2d_tm_field_update_unit.sv
// channel   signals                                             handshake
// config    psel penable pwrite paddr pwdata prdata pready      apb, pready tied high
// command   start operation source_value read_row/col/field     start && !busy
// result    done read_value steps_done saturated                one-cycle strobe
// after reset a clearing pass of 4096 cells zeroes the three grids, busy meanwhile
// a step takes three passes of 4096 cells, each cell read and then updated through
// the shared adder, plus one source write between the Ez and Hx passes
// a read passes through the registered memory port
// the result beat comes in the same cycle that busy falls, shown for one cycle only
// the receiver cannot stall
`include "assert_macros.svh"
module fdtd_2d_tm_field_update_unit
    import fdtd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic                 operation,
    input  logic signed [17:0]   source_value,
    input  logic [5:0]           read_row,
    input  logic [5:0]           read_col,
    input  logic [1:0]           read_field,
    output logic                 done,
    output logic signed [17:0]   read_value,
    output logic [15:0]          steps_done,
    output logic                 saturated
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EZ    = 3'd2;
    localparam logic [2:0] ST_SRC   = 3'd3;
    localparam logic [2:0] ST_HX    = 3'd4;
    localparam logic [2:0] ST_HY    = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [ADDR_BITS-1:0] idx_reg, idx_next;
    logic                 phase_reg, phase_next;
    logic [GRID_BITS-1:0] src_row_reg, src_col_reg;
    field_t               src_val_reg;
    logic [ADDR_BITS-1:0] rd_addr_reg;
    logic [1:0]           rd_field_reg;
    logic [15:0]          count_reg, count_next;
    logic                 clip_reg, clip_next;
    logic                 done_reg, done_next;
    logic signed [17:0]   rv_reg, rv_next;
    logic                 sat_reg, sat_next;

    logic [GRID_BITS-1:0] row, col;
    logic                 last_cell;
    logic [ADDR_BITS-1:0] src_addr;
    logic [ADDR_BITS-1:0] ez_ra, h_ra, waddr;
    logic                 ez_we, hx_we, hy_we;
    field_t               ez_a, ez_b, hx_a, hx_b, hy_a, hy_b;
    field_t               wdata;
    alu_op_t              op;
    alu_res_t             res;
    logic                 cfg_wr;

    assign row       = idx_reg[ADDR_BITS-1:GRID_BITS];
    assign col       = idx_reg[GRID_BITS-1:0];
    assign last_cell = (idx_reg == {ADDR_BITS{1'b1}});
    assign src_addr  = {src_row_reg, src_col_reg};
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SOURCE_COL) ? {26'd0, src_col_reg}
                                                    : {26'd0, src_row_reg};

    always_comb
    begin
        case (state_reg)
            ST_HX:   ez_ra = idx_reg + ADDR_BITS'(1);
            ST_HY:   ez_ra = idx_reg + ADDR_BITS'(DEPTH >> GRID_BITS);
            ST_READ: ez_ra = rd_addr_reg;
            default: ez_ra = idx_reg;
        endcase
        h_ra  = (state_reg == ST_READ) ? rd_addr_reg : idx_reg;
        waddr = (state_reg == ST_SRC) ? src_addr : idx_reg;
    end

    always_comb
    begin
        op = '0;
        case (state_reg)
            ST_EZ:
            begin
                op.base = ez_a;
                op.pa   = hy_a;
                op.na   = hy_b;
                op.pb   = hx_b;
                op.nb   = hx_a;
            end
            ST_SRC:
            begin
                op.base = src_val_reg;
            end
            ST_HX:
            begin
                op.base   = hx_a;
                op.pa     = ez_a;
                op.na     = ez_b;
                op.negate = 1'b1;
            end
            ST_HY:
            begin
                op.base = hy_a;
                op.pa   = ez_a;
                op.na   = ez_b;
            end
            default: op = '0;
        endcase
    end

    fdtd_alu u_alu (
        .op  (op),
        .res (res)
    );

    assign wdata = (state_reg == ST_CLEAR) ? '0 : res.value;
    assign ez_we = (state_reg == ST_CLEAR) || (state_reg == ST_SRC) ||
                   ((state_reg == ST_EZ) && phase_reg && (row != '0) && (col != '0));
    assign hx_we = (state_reg == ST_CLEAR) ||
                   ((state_reg == ST_HX) && phase_reg && (row != GRID_LAST) && (col != GRID_LAST));
    assign hy_we = (state_reg == ST_CLEAR) ||
                   ((state_reg == ST_HY) && phase_reg && (row != GRID_LAST) && (col != GRID_LAST));

    fdtd_ram #(.WIDTH(FIELD_BITS), .ABITS(ADDR_BITS)) u_ez (
        .clk     (clk),
        .we      (ez_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (ez_ra),
        .raddr_b (idx_reg),
        .rdata_a (ez_a),
        .rdata_b (ez_b)
    );

    fdtd_ram #(.WIDTH(FIELD_BITS), .ABITS(ADDR_BITS)) u_hx (
        .clk     (clk),
        .we      (hx_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (h_ra),
        .raddr_b (idx_reg - ADDR_BITS'(1)),
        .rdata_a (hx_a),
        .rdata_b (hx_b)
    );

    fdtd_ram #(.WIDTH(FIELD_BITS), .ABITS(ADDR_BITS)) u_hy (
        .clk     (clk),
        .we      (hy_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (h_ra),
        .raddr_b (idx_reg - ADDR_BITS'(DEPTH >> GRID_BITS)),
        .rdata_a (hy_a),
        .rdata_b (hy_b)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        clip_next  = clip_reg;
        done_next  = 1'b0;
        rv_next    = rv_reg;
        sat_next   = sat_reg;
        if ((hx_we || hy_we || ez_we) && state_reg != ST_CLEAR && res.clip)
        begin
            clip_next = 1'b1;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_reg + ADDR_BITS'(1);
                if (last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                idx_next   = '0;
                phase_next = 1'b0;
                if (start)
                begin
                    clip_next  = 1'b0;
                    state_next = (operation == OP_READ) ? ST_READ : ST_EZ;
                end
            end
            ST_EZ, ST_HX, ST_HY:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    idx_next = idx_reg + ADDR_BITS'(1);
                    if (last_cell)
                    begin
                        case (state_reg)
                            ST_EZ:   state_next = ST_SRC;
                            ST_HX:   state_next = ST_HY;
                            default:
                            begin
                                state_next = ST_IDLE;
                                count_next = count_reg + 16'd1;
                                done_next  = 1'b1;
                                rv_next    = '0;
                                sat_next   = clip_next;
                            end
                        endcase
                    end
                end
            end
            ST_SRC:
            begin
                state_next = ST_HX;
            end
            ST_READ:
            begin
                phase_next = 1'b1;
                if (phase_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    sat_next   = 1'b0;
                    case (rd_field_reg)
                        FIELD_EZ: rv_next = 18'(ez_a);
                        FIELD_HX: rv_next = 18'(hx_a);
                        FIELD_HY: rv_next = 18'(hy_a);
                        default:  rv_next = '0;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            phase_reg   <= 1'b0;
            count_reg   <= '0;
            clip_reg    <= 1'b0;
            done_reg    <= 1'b0;
            src_row_reg <= GRID_BITS'(32);
            src_col_reg <= GRID_BITS'(32);
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            clip_reg  <= clip_next;
            done_reg  <= done_next;
            if (cfg_wr && paddr[2] == REG_SOURCE_ROW)
            begin
                src_row_reg <= pwdata[GRID_BITS-1:0];
            end
            if (cfg_wr && paddr[2] == REG_SOURCE_COL)
            begin
                src_col_reg <= pwdata[GRID_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg  <= rv_next;
        sat_reg <= sat_next;
        if (state_reg == ST_IDLE && start)
        begin
            src_val_reg  <= source_value;
            rd_addr_reg  <= {read_row, read_col};
            rd_field_reg <= read_field;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign read_value = rv_reg;
    assign steps_done = count_reg;
    assign saturated  = sat_reg;

    `CHECK_IMPL(a_done_idle, clk, rst_n, done |-> !busy)
    `CHECK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `CHECK_NEXT(a_done_single, clk, rst_n, done, !done)
endmodule
